FILE: rtl/core/slfp_pkg.sv
// Shared types and character codes for the status line field parser.
package slfp_pkg;

  // Parser position within one line.
  typedef enum logic [3:0] {
    ST_START      = 4'd0,
    ST_C1         = 4'd1,
    ST_R1         = 4'd2,
    ST_P1         = 4'd3,
    ST_NUMC       = 4'd4,
    ST_NUMC_DIG   = 4'd5,
    ST_NUMR       = 4'd6,
    ST_NUMR_DIG   = 4'd7,
    ST_SEMI1      = 4'd8,
    ST_SEMI2      = 4'd9,
    ST_NAME_FIRST = 4'd10,
    ST_NAME       = 4'd11,
    ST_RAM        = 4'd12,
    ST_IGNORE     = 4'd13
  } stage_t;

  // Character codes the parser looks for.
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_NUL   = 8'h00;

  // Sign and whitespace tracking codes.
  localparam logic [1:0] SGN_NONE  = 2'd0;
  localparam logic [1:0] SGN_SPACE = 2'd1;
  localparam logic [1:0] SGN_PLUS  = 2'd2;
  localparam logic [1:0] SGN_MINUS = 2'd3;

  // Result kinds.
  localparam logic KIND_ENTRY = 1'b0;
  localparam logic KIND_SUM   = 1'b1;

  // Saturation limits of the number accumulator.
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;
  localparam logic [31:0] POS_MAX   = 32'h7FFF_FFFF;

  // Result queue geometry.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = 2;
  localparam int CNT_W      = 3;

  // One result word.
  typedef struct packed {
    logic        kind;
    logic [3:0]  entry_index;
    logic [55:0] name_text;
    logic [2:0]  name_length;
    logic [55:0] ram_text;
    logic [2:0]  ram_length;
    logic [31:0] cpu_percent;
    logic [31:0] ram_percent;
    logic [4:0]  entry_count;
    logic        last;
  } res_t;

endpackage

FILE: rtl/core/status_line_field_parser_core.sv
// Status line field parser: character parser and result queue.
//
// Usage: characters of a line of the form C:<int>;R:<int>;P:name,ram,...
// enter one word per cycle on the in_ channel (valid/ready). A word with
// in_line_end set, or a zero character, closes the line. Each completed
// name/ram entry and the end-of-line summary leave as words on the out_
// channel; out_last marks the final result of the input word that caused it.
// Each result is written into the result queue when its input word is
// accepted. Throughput: one input word per cycle while in_ready is high; the
// parser computes its next state with a shift-and-add multiply by ten for digits.
// A line end closing an open entry produces two results, which drain one at a
// time through the four-word result queue.
// in_ready is high while the queue has room for two words, so input keeps
// flowing while a result waits; a stalled receiver fills the queue and then
// holds off input. Reset (rst_n low, synchronous) returns the parser to line
// start with all values cleared and empties the queue.
module status_line_field_parser_core
  import slfp_pkg::*;
#(
  parameter int MAX_ENTRIES = 16,
  parameter int NAME_BYTES  = 8,
  parameter int RAM_BYTES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_char_byte,
  input  logic        in_line_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [3:0]  out_entry_index,
  output logic [55:0] out_name_text,
  output logic [2:0]  out_name_length,
  output logic [55:0] out_ram_text,
  output logic [2:0]  out_ram_length,
  output logic [31:0] out_cpu_percent,
  output logic [31:0] out_ram_percent,
  output logic [4:0]  out_entry_count,
  output logic        out_last
);

  localparam logic [4:0] MAX_CNT   = 5'(MAX_ENTRIES);
  localparam logic [2:0] NAME_KEEP = 3'(NAME_BYTES - 1);
  localparam logic [2:0] RAM_KEEP  = 3'(RAM_BYTES - 1);

  // Parser state.
  stage_t      stage_r, stage_nxt;
  logic [1:0]  sign_r, sign_nxt;
  logic [31:0] accum_r, accum_nxt;
  logic [31:0] cpu_r, cpu_nxt;
  logic [31:0] ram_r, ram_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [55:0] nbuf_r, nbuf_nxt;
  logic [2:0]  nfill_r, nfill_nxt;
  logic [55:0] rbuf_r, rbuf_nxt;
  logic [2:0]  rfill_r, rfill_nxt;

  // Result queue.
  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  logic        in_fire, out_fire, eol;
  logic [7:0]  ch;
  logic [35:0] prod;
  logic [31:0] acc_step, fin_val, cpu_fin, ram_fin;
  logic        is_ram_num;
  logic [55:0] nbase;
  logic [2:0]  nfbase;
  res_t        res0, res1;
  logic [1:0]  nres;
  res_t        head;

  function automatic logic is_ws(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic stage_t from_semi2(logic [7:0] c);
    return (c == CH_P) ? ST_P1 : ST_IGNORE;
  endfunction

  function automatic stage_t from_post_r(logic [7:0] c);
    return (c == CH_SEMI) ? ST_SEMI2 : from_semi2(c);
  endfunction

  function automatic stage_t from_semi1(logic [7:0] c);
    return (c == CH_R) ? ST_R1 : from_post_r(c);
  endfunction

  function automatic stage_t from_post_c(logic [7:0] c);
    return (c == CH_SEMI) ? ST_SEMI1 : from_semi1(c);
  endfunction

  // Place one character in the byte lane selected by the fill count.
  function automatic logic [55:0] put_byte(logic [55:0] b, logic [2:0] fill, logic [7:0] c);
    logic [55:0] r;
    r = b;
    for (int i = 0; i < 7; i++) begin
      if (fill == 3'(i)) begin
        r[i*8 +: 8] = c;
      end
    end
    return r;
  endfunction

  function automatic res_t make_entry(logic [4:0] cnt, logic [55:0] nb, logic [2:0] nf,
                                      logic [55:0] rb, logic [2:0] rf, logic lst);
    res_t r;
    r             = '0;
    r.kind        = KIND_ENTRY;
    r.entry_index = 4'(cnt - 5'd1);
    r.name_text   = nb;
    r.name_length = nf;
    r.ram_text    = rb;
    r.ram_length  = rf;
    r.entry_count = cnt;
    r.last        = lst;
    return r;
  endfunction

  function automatic res_t make_sum(logic [31:0] cpu, logic [31:0] ram, logic [4:0] cnt);
    res_t r;
    r             = '0;
    r.kind        = KIND_SUM;
    r.cpu_percent = cpu;
    r.ram_percent = ram;
    r.entry_count = cnt;
    r.last        = 1'b1;
    return r;
  endfunction

  assign in_ready  = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign ch        = in_char_byte;
  assign eol       = in_line_end || (ch == CH_NUL);

  // Accumulator update: times ten by shift and add, saturating at 2^31.
  assign prod     = ({4'd0, accum_r} << 3) + ({4'd0, accum_r} << 1) + {32'd0, ch[3:0]};
  assign acc_step = (prod > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[31:0];

  // Finished value of the number under way.
  assign fin_val = (sign_r == SGN_MINUS) ? (32'd0 - accum_r) :
                   (accum_r[31] ? POS_MAX : accum_r);

  // Next parser state and the results of the accepted word.
  always_comb begin
    stage_nxt  = stage_r;
    sign_nxt   = sign_r;
    accum_nxt  = accum_r;
    cpu_nxt    = cpu_r;
    ram_nxt    = ram_r;
    cnt_nxt    = cnt_r;
    nbuf_nxt   = nbuf_r;
    nfill_nxt  = nfill_r;
    rbuf_nxt   = rbuf_r;
    rfill_nxt  = rfill_r;
    res0       = '0;
    res1       = '0;
    nres       = 2'd0;
    cpu_fin    = cpu_r;
    ram_fin    = ram_r;
    is_ram_num = (stage_r == ST_NUMR) || (stage_r == ST_NUMR_DIG);
    nbase      = nbuf_r;
    nfbase     = nfill_r;
    if (in_fire && eol) begin
      // Line end: close any number, report an open entry, then the summary.
      if (stage_r == ST_NUMC_DIG) begin
        cpu_fin = fin_val;
      end else if (stage_r == ST_NUMR_DIG) begin
        ram_fin = fin_val;
      end
      if (stage_r == ST_RAM) begin
        res0 = make_entry(cnt_r + 5'd1, nbuf_r, nfill_r, rbuf_r, rfill_r, 1'b0);
        res1 = make_sum(cpu_fin, ram_fin, cnt_r + 5'd1);
        nres = 2'd2;
      end else begin
        res0 = make_sum(cpu_fin, ram_fin, cnt_r);
        nres = 2'd1;
      end
      stage_nxt = ST_START;
      sign_nxt  = SGN_NONE;
      accum_nxt = '0;
      cpu_nxt   = '0;
      ram_nxt   = '0;
      cnt_nxt   = '0;
      nbuf_nxt  = '0;
      nfill_nxt = '0;
      rbuf_nxt  = '0;
      rfill_nxt = '0;
    end else if (in_fire) begin
      case (stage_r)
        ST_START: begin
          stage_nxt = (ch == CH_C) ? ST_C1 : from_post_c(ch);
        end
        ST_C1, ST_R1: begin
          if (ch == CH_COLON) begin
            sign_nxt  = SGN_NONE;
            accum_nxt = '0;
            stage_nxt = (stage_r == ST_C1) ? ST_NUMC : ST_NUMR;
          end else begin
            stage_nxt = ST_IGNORE;
          end
        end
        ST_P1: begin
          stage_nxt = (ch == CH_COLON) ? ST_NAME_FIRST : ST_IGNORE;
        end
        ST_NUMC, ST_NUMC_DIG, ST_NUMR, ST_NUMR_DIG: begin
          if (is_digit(ch)) begin
            accum_nxt = acc_step;
            stage_nxt = is_ram_num ? ST_NUMR_DIG : ST_NUMC_DIG;
          end else if ((stage_r == ST_NUMC_DIG) || (stage_r == ST_NUMR_DIG)) begin
            // Number ends; the character is read as what follows it.
            if (is_ram_num) begin
              ram_nxt   = fin_val;
              stage_nxt = from_post_r(ch);
            end else begin
              cpu_nxt   = fin_val;
              stage_nxt = from_post_c(ch);
            end
          end else if (sign_r == SGN_NONE) begin
            if (is_ws(ch)) begin
              sign_nxt = SGN_SPACE;
            end else if (ch == CH_PLUS) begin
              sign_nxt = SGN_PLUS;
            end else if (ch == CH_MINUS) begin
              sign_nxt = SGN_MINUS;
            end else begin
              stage_nxt = is_ram_num ? from_post_r(ch) : from_post_c(ch);
            end
          end else if ((sign_r == SGN_SPACE) &&
                       (is_ws(ch) || (ch == CH_PLUS) || (ch == CH_MINUS))) begin
            if (ch == CH_PLUS) begin
              sign_nxt = SGN_PLUS;
            end else if (ch == CH_MINUS) begin
              sign_nxt = SGN_MINUS;
            end
          end else begin
            stage_nxt = ST_IGNORE;
          end
        end
        ST_SEMI1: begin
          stage_nxt = from_semi1(ch);
        end
        ST_SEMI2: begin
          stage_nxt = from_semi2(ch);
        end
        ST_NAME_FIRST, ST_NAME: begin
          if ((stage_r == ST_NAME_FIRST) && ((cnt_r >= MAX_CNT) || (ch == CH_SEMI))) begin
            stage_nxt = ST_IGNORE;
          end else begin
            // A new entry starts with empty buffers.
            if (stage_r == ST_NAME_FIRST) begin
              nbase     = '0;
              nfbase    = '0;
              nbuf_nxt  = '0;
              nfill_nxt = '0;
              rbuf_nxt  = '0;
              rfill_nxt = '0;
              stage_nxt = ST_NAME;
            end
            if (ch == CH_COMMA) begin
              stage_nxt = ST_RAM;
            end else if (nfbase < NAME_KEEP) begin
              nbuf_nxt  = put_byte(nbase, nfbase, ch);
              nfill_nxt = nfbase + 3'd1;
            end
          end
        end
        ST_RAM: begin
          if (ch == CH_COMMA) begin
            cnt_nxt   = cnt_r + 5'd1;
            res0      = make_entry(cnt_r + 5'd1, nbuf_r, nfill_r, rbuf_r, rfill_r, 1'b1);
            nres      = 2'd1;
            stage_nxt = ST_NAME_FIRST;
          end else if (rfill_r < RAM_KEEP) begin
            rbuf_nxt  = put_byte(rbuf_r, rfill_r, ch);
            rfill_nxt = rfill_r + 3'd1;
          end
        end
        default: begin
          stage_nxt = ST_IGNORE;
        end
      endcase
    end
  end

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_r <= ST_START;
      sign_r  <= SGN_NONE;
      accum_r <= '0;
      cpu_r   <= '0;
      ram_r   <= '0;
      cnt_r   <= '0;
      nbuf_r  <= '0;
      nfill_r <= '0;
      rbuf_r  <= '0;
      rfill_r <= '0;
    end else begin
      stage_r <= stage_nxt;
      sign_r  <= sign_nxt;
      accum_r <= accum_nxt;
      cpu_r   <= cpu_nxt;
      ram_r   <= ram_nxt;
      cnt_r   <= cnt_nxt;
      nbuf_r  <= nbuf_nxt;
      nfill_r <= nfill_nxt;
      rbuf_r  <= rbuf_nxt;
      rfill_r <= rfill_nxt;
    end
  end

  // Result queue storage; up to two words are written per accepted input.
  always_ff @(posedge clk) begin
    if (nres != 2'd0) begin
      fifo_r[wr_ptr_r] <= res0;
    end
    if (nres == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= res1;
    end
  end

  // Result queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(nres);
      rd_ptr_r <= rd_ptr_r + PTR_W'(out_fire);
      count_r  <= count_r + CNT_W'(nres) - CNT_W'(out_fire);
    end
  end

  // Head of the queue drives the output word.
  assign head            = fifo_r[rd_ptr_r];
  assign out_kind        = head.kind;
  assign out_entry_index = head.entry_index;
  assign out_name_text   = head.name_text;
  assign out_name_length = head.name_length;
  assign out_ram_text    = head.ram_text;
  assign out_ram_length  = head.ram_length;
  assign out_cpu_percent = head.cpu_percent;
  assign out_ram_percent = head.ram_percent;
  assign out_entry_count = head.entry_count;
  assign out_last        = head.last;

  // The queue never holds more words than it has room for.
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overfilled");

  // A line end always returns the parser to line start with no entries.
  a_eol_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && eol) |=> (stage_r == ST_START) && (cnt_r == '0))
    else $error("parser not cleared after line end");

  // Entry results carry a count one past their index.
  a_entry_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_ENTRY)) |->
      (out_entry_count == ({1'b0, out_entry_index} + 5'd1)))
    else $error("entry index and count disagree");

  // A summary is always the final result of its input word.
  a_sum_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_SUM)) |-> out_last)
    else $error("summary without last flag");

  // The entry counter stays within the configured limit.
  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_CNT)
    else $error("entry counter past limit");

endmodule

FILE: sim/status_line_field_parser_core_test.sv
// Self-checking testbench for the status line field parser core.
module status_line_field_parser_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slfp_pkg::*;

  localparam int MAX_ENTRIES = 16;
  localparam int NAME_BYTES  = 8;
  localparam int RAM_BYTES   = 8;

  // Line predictor and store of expected result words.
  class line_scoreboard;
    stage_t      stage;
    logic [1:0]  sgn;
    logic [31:0] mag;
    logic [31:0] cpu;
    logic [31:0] ram;
    logic [4:0]  n_entries;
    logic [55:0] name_buf;
    logic [2:0]  name_fill;
    logic [55:0] ram_buf;
    logic [2:0]  ram_fill;
    res_t        expected_q[$];
    int          errors;

    function new();
      errors = 0;
      clear_line();
    endfunction

    function void clear_line();
      stage     = ST_START;
      sgn       = SGN_NONE;
      mag       = '0;
      cpu       = '0;
      ram       = '0;
      n_entries = '0;
      name_buf  = '0;
      name_fill = '0;
      ram_buf   = '0;
      ram_fill  = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function bit is_space(logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // Section transitions once a field is over.
    function stage_t after_semi2(logic [7:0] c);
      if (c == CH_P) return ST_P1;
      return ST_IGNORE;
    endfunction

    function stage_t after_r(logic [7:0] c);
      if (c == CH_SEMI) return ST_SEMI2;
      return after_semi2(c);
    endfunction

    function stage_t after_semi1(logic [7:0] c);
      if (c == CH_R) return ST_R1;
      return after_r(c);
    endfunction

    function stage_t after_c(logic [7:0] c);
      if (c == CH_SEMI) return ST_SEMI1;
      return after_semi1(c);
    endfunction

    // Apply the sign to the saturated magnitude and store the value.
    function void finish_number(bit is_r);
      logic [31:0] v;
      if (sgn == SGN_MINUS) v = 32'd0 - mag;
      else v = (mag > POS_MAX) ? POS_MAX : mag;
      if (is_r) ram = v;
      else cpu = v;
    endfunction

    // Returns 1 when the number field consumes the character.
    function bit number_char(logic [7:0] c, bit is_r, bit digits);
      logic [63:0] m;
      if (is_digit(c)) begin
        m = 64'(mag) * 64'd10 + 64'(c - CH_ZERO);
        if (m > 64'(MAG_LIMIT)) m = 64'(MAG_LIMIT);
        mag = m[31:0];
        if (is_r) stage = ST_NUMR_DIG;
        else stage = ST_NUMC_DIG;
        return 1'b1;
      end
      if (digits) begin
        finish_number(is_r);
        return 1'b0;
      end
      if (sgn == SGN_NONE || sgn == SGN_SPACE) begin
        if (is_space(c)) begin
          sgn = SGN_SPACE;
          return 1'b1;
        end
        if (c == CH_PLUS) begin
          sgn = SGN_PLUS;
          return 1'b1;
        end
        if (c == CH_MINUS) begin
          sgn = SGN_MINUS;
          return 1'b1;
        end
        if (sgn == SGN_NONE) return 1'b0;
      end
      stage = ST_IGNORE;
      return 1'b1;
    endfunction

    function res_t make_result(logic kind, logic last);
      res_t r;
      r = '0;
      r.kind        = kind;
      r.entry_count = n_entries;
      r.last        = last;
      if (kind == KIND_ENTRY) begin
        r.entry_index = 4'(n_entries - 5'd1);
        r.name_text   = name_buf;
        r.name_length = name_fill;
        r.ram_text    = ram_buf;
        r.ram_length  = ram_fill;
      end else begin
        r.cpu_percent = cpu;
        r.ram_percent = ram;
      end
      return r;
    endfunction

    // Advance the predictor by one accepted input word.
    function void note_word(logic [7:0] c, logic le);
      if (le || c == CH_NUL) begin
        if (stage == ST_NUMC_DIG) finish_number(1'b0);
        else if (stage == ST_NUMR_DIG) finish_number(1'b1);
        if (stage == ST_RAM) begin
          n_entries++;
          expected_q.push_back(make_result(KIND_ENTRY, 1'b0));
        end
        expected_q.push_back(make_result(KIND_SUM, 1'b1));
        clear_line();
        return;
      end
      case (stage)
        ST_START: begin
          if (c == CH_C) stage = ST_C1;
          else stage = after_c(c);
        end
        ST_C1, ST_R1: begin
          if (c == CH_COLON) begin
            sgn = SGN_NONE;
            mag = '0;
            if (stage == ST_C1) stage = ST_NUMC;
            else stage = ST_NUMR;
          end else begin
            stage = ST_IGNORE;
          end
        end
        ST_P1: begin
          if (c == CH_COLON) stage = ST_NAME_FIRST;
          else stage = ST_IGNORE;
        end
        ST_NUMC, ST_NUMC_DIG: begin
          if (!number_char(c, 1'b0, stage == ST_NUMC_DIG)) stage = after_c(c);
        end
        ST_NUMR, ST_NUMR_DIG: begin
          if (!number_char(c, 1'b1, stage == ST_NUMR_DIG)) stage = after_r(c);
        end
        ST_SEMI1: stage = after_semi1(c);
        ST_SEMI2: stage = after_semi2(c);
        ST_NAME_FIRST, ST_NAME: begin
          if (stage == ST_NAME_FIRST && (n_entries >= MAX_ENTRIES || c == CH_SEMI)) begin
            stage = ST_IGNORE;
          end else begin
            // A new entry starts with empty buffers.
            if (stage == ST_NAME_FIRST) begin
              name_buf  = '0;
              name_fill = '0;
              ram_buf   = '0;
              ram_fill  = '0;
              stage     = ST_NAME;
            end
            if (c == CH_COMMA) begin
              stage = ST_RAM;
            end else if (name_fill < NAME_BYTES - 1) begin
              name_buf[name_fill*8 +: 8] = c;
              name_fill++;
            end
          end
        end
        ST_RAM: begin
          if (c == CH_COMMA) begin
            n_entries++;
            expected_q.push_back(make_result(KIND_ENTRY, 1'b1));
            stage = ST_NAME_FIRST;
          end else if (ram_fill < RAM_BYTES - 1) begin
            ram_buf[ram_fill*8 +: 8] = c;
            ram_fill++;
          end
        end
        default: stage = ST_IGNORE;
      endcase
    endfunction

    function string show(res_t r);
      return $sformatf({"kind=%0d idx=%0d name=%h/%0d ram=%h/%0d ",
                        "cpu=%0d rampct=%0d cnt=%0d last=%0d"},
                       r.kind, r.entry_index, r.name_text, r.name_length, r.ram_text,
                       r.ram_length, $signed(r.cpu_percent), $signed(r.ram_percent),
                       r.entry_count, r.last);
    endfunction

    function void note_error(string msg);
      errors++;
      if (errors <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Compare one result word with the oldest expectation.
    function void check_word(res_t got);
      res_t want;
      if (expected_q.size() == 0) begin
        note_error({"unexpected result ", show(got)});
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind || got.entry_index !== want.entry_index ||
          got.name_text !== want.name_text || got.name_length !== want.name_length ||
          got.ram_text !== want.ram_text || got.ram_length !== want.ram_length ||
          got.cpu_percent !== want.cpu_percent || got.ram_percent !== want.ram_percent ||
          got.entry_count !== want.entry_count || got.last !== want.last)
        note_error({"expected ", show(want), " actual ", show(got)});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_byte = '0;
  logic        in_line_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [3:0]  out_entry_index;
  logic [55:0] out_name_text;
  logic [2:0]  out_name_length;
  logic [55:0] out_ram_text;
  logic [2:0]  out_ram_length;
  logic [31:0] out_cpu_percent;
  logic [31:0] out_ram_percent;
  logic [4:0]  out_entry_count;
  logic        out_last;

  line_scoreboard board;
  bit             calm = 1'b0;
  int             words_sent = 0;
  logic [7:0]     line_q[$];

  status_line_field_parser_core u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_byte   (in_char_byte),
    .in_line_end    (in_line_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_kind       (out_kind),
    .out_entry_index(out_entry_index),
    .out_name_text  (out_name_text),
    .out_name_length(out_name_length),
    .out_ram_text   (out_ram_text),
    .out_ram_length (out_ram_length),
    .out_cpu_percent(out_cpu_percent),
    .out_ram_percent(out_ram_percent),
    .out_entry_count(out_entry_count),
    .out_last       (out_last)
  );

  // 8 ns clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Watchdog for a hung run.
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

  // Send one word after a random gap and wait for its acceptance.
  task automatic send_word(input logic [7:0] c, input logic le);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_byte <= c;
    in_line_end  <= le;
    do @(posedge clk); while (!in_ready);
    board.note_word(c, le);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(8'(s[i]), 1'b0);
  endtask

  // Send the built line, closed by a line end word or a zero character.
  task automatic send_line();
    foreach (line_q[i]) send_word(line_q[i], 1'b0);
    if ($urandom_range(0, 4) == 0) send_word(CH_NUL, 1'b0);
    else send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Hold off input until every expected result has arrived.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
    repeat (3) @(posedge clk);
  endtask

  function automatic void append_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(8'(s[i]));
  endfunction

  function automatic logic [7:0] pick_space();
    int r;
    r = $urandom_range(0, 5);
    return (r == 5) ? CH_SPACE : CH_TAB + 8'(r);
  endfunction

  // Number text: optional whitespace and sign, then digits of random length or a value around 2^31.
  function automatic void add_number();
    int pick;
    int ndig;
    pick = $urandom_range(0, 19);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(pick_space());
    case ($urandom_range(0, 5))
      0: line_q.push_back(CH_PLUS);
      1: line_q.push_back(CH_MINUS);
      default: ;
    endcase
    if ($urandom_range(0, 11) == 0) line_q.push_back(pick_space());
    if (pick == 0) append_text("2147483647");
    else if (pick == 1) append_text("2147483648");
    else if (pick == 2) append_text("2147483649");
    else begin
      ndig = $urandom_range(0, 9);
      if (ndig == 0) ndig = 0;
      else if (ndig == 1) ndig = $urandom_range(9, 14);
      else ndig = $urandom_range(1, 4);
      repeat (ndig) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    end
  endfunction

  // Process entries; the last one may lack its closing comma or its name comma.
  function automatic void add_entries();
    int n;
    int len;
    int style;
    n = ($urandom_range(0, 11) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 3);
    style = $urandom_range(0, 2);
    for (int e = 0; e < n; e++) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
      for (int k = 0; k < len; k++)
        line_q.push_back(($urandom_range(0, 9) == 0) ? CH_SEMI : 8'h61 + 8'($urandom_range(0, 25)));
      if (e == n - 1 && style == 2) break;
      line_q.push_back(CH_COMMA);
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
      repeat (len) line_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
      if (!(e == n - 1 && style == 1)) line_q.push_back(CH_COMMA);
    end
  endfunction

  // Mostly well-formed lines; some pure noise and some with one corrupted byte.
  function automatic void gen_line();
    int pick;
    line_q.delete();
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      repeat ($urandom_range(1, 12)) line_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    if ($urandom_range(0, 3) != 0) begin
      append_text("C:");
      add_number();
      if ($urandom_range(0, 3) != 0) line_q.push_back(CH_SEMI);
    end
    if ($urandom_range(0, 3) != 0) begin
      append_text("R:");
      add_number();
      if ($urandom_range(0, 3) != 0) line_q.push_back(CH_SEMI);
    end else if ($urandom_range(0, 5) == 0) begin
      line_q.push_back(CH_SEMI);
    end
    if ($urandom_range(0, 4) != 0) begin
      append_text("P:");
      add_entries();
    end
    if (pick == 1 && line_q.size() > 0)
      line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
  endfunction

  // Result side: random stall before each word, then check it.
  initial begin : result_sink
    int   stall;
    res_t got;
    forever begin
      stall = calm ? 0 : $urandom_range(0, 19);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_valid === 1'b1));
      got.kind        = out_kind;
      got.entry_index = out_entry_index;
      got.name_text   = out_name_text;
      got.name_length = out_name_length;
      got.ram_text    = out_ram_text;
      got.ram_length  = out_ram_length;
      got.cpu_percent = out_cpu_percent;
      got.ram_percent = out_ram_percent;
      got.entry_count = out_entry_count;
      got.last        = out_last;
      board.check_word(got);
    end
  end

  // Stimulus: reset, directed lines, then random lines.
  initial begin : stimulus
    int lines;
    int start_words;
    int waited;
    board = new();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Negative overflow, whitespace then sign, a name holding ';', entry closed by line end.
    send_text("C:-99999999999;R: +42;P:a;b,12");
    send_word(CH_NUL, 1'b1);
    // Number with no digits before R, an empty entry, zero character as line end.
    send_text("C:R:7;P:,,");
    send_word(CH_NUL, 1'b0);
    // Whitespace after a sign drops the rest of the line.
    send_text("C:+ 1");
    send_word(8'hFF, 1'b1);
    // Broken prefix, then ';' at the start of an entry.
    send_text("Q");
    send_word(CH_NUL, 1'b1);
    send_text("P:;x");
    send_word(8'hA5, 1'b1);
    hold_until_drained();

    // Random lines, with a full drain every few lines.
    lines = 0;
    start_words = words_sent;
    while (words_sent - start_words < 650) begin
      calm = ($urandom_range(0, 4) == 0);
      gen_line();
      send_line();
      lines++;
      if (lines % 9 == 0) hold_until_drained();
    end
    in_valid <= 1'b0;
    calm = 1'b0;

    // Let the last results drain, then watch on for stray words.
    waited = 0;
    while (board.pending() != 0 && waited < 200000) begin
      @(posedge clk);
      waited++;
    end
    repeat (20) @(posedge clk);
    if (board.pending() != 0) board.note_error($sformatf("%0d results never arrived",
                                                         board.pending()));
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
